[rtl/core/rabe_pkg.sv]
`default_nettype none

package rabe_pkg;

  // Data path and register file geometry.
  localparam int DATA_W     = 32;
  localparam int REG_COUNT  = 8;
  localparam int REG_IDX_W  = 3;
  localparam int TARGET_W   = 10;
  localparam int CFG_IDX_W  = 3;

  // Width of the iteration counter of the shift-add multiply and the restoring divide.
  localparam int ITER_W     = $clog2(DATA_W);
  localparam int CNT_W      = (ITER_W > REG_IDX_W) ? ITER_W : REG_IDX_W;

  // Operation codes carried by each beat on the input channel.
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_ADDI = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_B    = 3'd5,
    OP_BEQ  = 3'd6,
    OP_BNQ  = 3'd7
  } op_t;

  typedef logic [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

[rtl/core/register_alu_branch_execute.sv]
// Integer ALU with branch compare over an eight-entry 32-bit register file.
//
// Input channel (in_*): one decoded instruction per beat, taken when in_valid
// is high and in_stall is low. Result channel (out_*): one result beat per
// instruction, taken when out_valid is high and out_stall is low. Config port
// (cfg_*): cfg_write_enable writes cfg_data into the initial-value register
// at cfg_index; the user must use it only while idle, which is not enforced.
//
// One instruction is in flight at a time. Add, addi, sub and the branches
// pass from acceptance through the read, execute and finish states; mul and
// div also walk 32 steps through the one shared 34-bit adder/subtractor
// (a zero divisor skips the walk). The next beat can be taken once the result
// is registered. A set restart flag adds a sweep that copies the initial
// values into the register file, one entry per cycle, through its single
// write port.
//
// A finished result sits in an output register, so the next beat is accepted
// while it waits; a stalled receiver holds the block only when the following
// result is ready to leave. Reset clears the initial values to zero, marks
// every register file entry as zero and leaves both channels empty.
`default_nettype none

module register_alu_branch_execute (
  input  wire                                clk,
  input  wire                                rst_n,
  // Configuration write port.
  input  wire                                cfg_write_enable,
  input  wire  [rabe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [rabe_pkg::DATA_W-1:0]        cfg_data,
  // Instruction channel.
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_restart,
  input  wire  [2:0]                         in_operation,
  input  wire  [rabe_pkg::REG_IDX_W-1:0]     in_operand_one,
  input  wire  [rabe_pkg::REG_IDX_W-1:0]     in_operand_two,
  input  wire  [rabe_pkg::REG_IDX_W-1:0]     in_operand_three,
  input  wire  signed [rabe_pkg::DATA_W-1:0] in_immediate,
  input  wire  [rabe_pkg::TARGET_W-1:0]      in_target_index,
  // Result channel.
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_write_enable,
  output logic [rabe_pkg::REG_IDX_W-1:0]     out_write_register,
  output logic signed [rabe_pkg::DATA_W-1:0] out_write_value,
  output logic                               out_branch_taken,
  output logic [rabe_pkg::TARGET_W-1:0]      out_next_index,
  output logic                               out_fetch_bubbles,
  output logic                               out_divide_by_zero
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_READ,
    ST_EXEC,
    ST_ITER,
    ST_FINISH
  } state_t;

  // Sequencer and operand registers.
  state_t                            state_r, state_nxt;
  rabe_pkg::op_t                     op_r, op_nxt;
  logic [rabe_pkg::REG_IDX_W-1:0]    r1_r, r1_nxt;
  logic [rabe_pkg::REG_IDX_W-1:0]    r2_r, r2_nxt;
  logic [rabe_pkg::REG_IDX_W-1:0]    r3_r, r3_nxt;
  rabe_pkg::word_t                   imm_r, imm_nxt;
  logic [rabe_pkg::TARGET_W-1:0]     target_r, target_nxt;
  logic [rabe_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  rabe_pkg::word_t                   acc_r, acc_nxt;
  rabe_pkg::word_t                   opx_r, opx_nxt;
  rabe_pkg::word_t                   opy_r, opy_nxt;
  logic                              negq_r, negq_nxt;
  logic                              dz_r, dz_nxt;

  // Output register.
  logic                              ov_r, ov_nxt;
  logic                              owe_r, owe_nxt;
  logic [rabe_pkg::REG_IDX_W-1:0]    oreg_r, oreg_nxt;
  rabe_pkg::word_t                   oval_r, oval_nxt;
  logic                              otaken_r, otaken_nxt;
  logic [rabe_pkg::TARGET_W-1:0]     oidx_r, oidx_nxt;
  logic                              obub_r, obub_nxt;
  logic                              odz_r, odz_nxt;

  // Initial-value registers and the register file.
  rabe_pkg::word_t                   init_r [rabe_pkg::REG_COUNT];
  rabe_pkg::word_t                   rf_mem [rabe_pkg::REG_COUNT];
  logic [rabe_pkg::REG_COUNT-1:0]    rf_valid_r;
  rabe_pkg::word_t                   rda_r, rdb_r;
  logic                              rf_we;
  logic [rabe_pkg::REG_IDX_W-1:0]    rf_waddr;
  rabe_pkg::word_t                   rf_wdata;
  logic [rabe_pkg::REG_IDX_W-1:0]    rf_raddr_a, rf_raddr_b;

  // Shared adder/subtractor.
  logic [rabe_pkg::DATA_W:0]         unit_x, unit_y;
  logic                              unit_sub;
  logic [rabe_pkg::DATA_W+1:0]       unit_sum;
  logic                              div_ge;

  logic                              in_fire;
  logic                              out_fire;
  logic                              fin_go;
  logic                              is_branch;
  logic                              iter_last;
  logic                              reload_last;
  rabe_pkg::word_t                   div_result;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_fire  = ov_r && !out_stall;
  assign fin_go    = (state_r == ST_FINISH) && (!ov_r || !out_stall);

  assign is_branch   = (op_r == rabe_pkg::OP_B) || (op_r == rabe_pkg::OP_BEQ) ||
                       (op_r == rabe_pkg::OP_BNQ);
  assign iter_last   = (cnt_r == rabe_pkg::CNT_W'(rabe_pkg::DATA_W - 1));
  assign reload_last = (cnt_r[rabe_pkg::REG_IDX_W-1:0] ==
                        rabe_pkg::REG_IDX_W'(rabe_pkg::REG_COUNT - 1));

  assign out_write_enable   = owe_r;
  assign out_write_register = oreg_r;
  assign out_write_value    = oval_r;
  assign out_branch_taken   = otaken_r;
  assign out_next_index     = oidx_r;
  assign out_fetch_bubbles  = obub_r;
  assign out_divide_by_zero = odz_r;

  // Operand selection for the shared unit, by sequencer step and operation.
  always_comb begin
    unit_x   = '0;
    unit_y   = '0;
    unit_sub = 1'b0;
    if (state_r == ST_EXEC) begin
      unit_x   = {1'b0, rda_r};
      unit_y   = {1'b0, (op_r == rabe_pkg::OP_ADDI) ? imm_r : rdb_r};
      unit_sub = (op_r == rabe_pkg::OP_SUB) || (op_r == rabe_pkg::OP_BEQ) ||
                 (op_r == rabe_pkg::OP_BNQ);
    end else if (state_r == ST_ITER) begin
      if (op_r == rabe_pkg::OP_DIV) begin
        // Restoring step: shifted remainder minus the divisor magnitude.
        unit_x   = {acc_r, opx_r[rabe_pkg::DATA_W-1]};
        unit_y   = {1'b0, opy_r};
        unit_sub = 1'b1;
      end else begin
        // Shift-add step: add the multiplicand when the multiplier bit is set.
        unit_x = {1'b0, acc_r};
        unit_y = {1'b0, opy_r[0] ? opx_r : '0};
      end
    end
  end

  assign unit_sum = {1'b0, unit_x} + ({1'b0, unit_y} ^ {(rabe_pkg::DATA_W + 2){unit_sub}}) +
                    (rabe_pkg::DATA_W + 2)'(unit_sub);
  assign div_ge   = !unit_sum[rabe_pkg::DATA_W+1];

  // Quotient sign fix-up; the most negative over minus one wraps by itself.
  assign div_result = dz_r ? '0 : (negq_r ? (~opx_r + rabe_pkg::DATA_W'(1)) : opx_r);

  // Register file ports: reads for the compare or source operands, one write.
  assign rf_raddr_a = is_branch ? r1_r : r2_r;
  assign rf_raddr_b = is_branch ? r2_r : r3_r;

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = r1_r;
    rf_wdata = acc_r;
    if (state_r == ST_RELOAD) begin
      rf_we    = 1'b1;
      rf_waddr = cnt_r[rabe_pkg::REG_IDX_W-1:0];
      rf_wdata = init_r[cnt_r[rabe_pkg::REG_IDX_W-1:0]];
    end else if (fin_go && !is_branch) begin
      rf_we    = 1'b1;
      rf_waddr = r1_r;
      rf_wdata = (op_r == rabe_pkg::OP_DIV) ? div_result : acc_r;
    end
  end

  // Next-state logic of the sequencer and the output register.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    r1_nxt     = r1_r;
    r2_nxt     = r2_r;
    r3_nxt     = r3_r;
    imm_nxt    = imm_r;
    target_nxt = target_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    opx_nxt    = opx_r;
    opy_nxt    = opy_r;
    negq_nxt   = negq_r;
    dz_nxt     = dz_r;
    ov_nxt     = ov_r && !out_fire;
    owe_nxt    = owe_r;
    oreg_nxt   = oreg_r;
    oval_nxt   = oval_r;
    otaken_nxt = otaken_r;
    oidx_nxt   = oidx_r;
    obub_nxt   = obub_r;
    odz_nxt    = odz_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt     = rabe_pkg::op_t'(in_operation);
          r1_nxt     = in_operand_one;
          r2_nxt     = in_operand_two;
          r3_nxt     = in_operand_three;
          imm_nxt    = in_immediate;
          target_nxt = in_target_index;
          cnt_nxt    = '0;
          dz_nxt     = 1'b0;
          negq_nxt   = 1'b0;
          state_nxt  = in_restart ? ST_RELOAD : ST_READ;
        end
      end
      ST_RELOAD: begin
        cnt_nxt = cnt_r + rabe_pkg::CNT_W'(1);
        if (reload_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cnt_nxt = '0;
        if (op_r == rabe_pkg::OP_MUL) begin
          acc_nxt   = '0;
          opx_nxt   = rda_r;
          opy_nxt   = rdb_r;
          state_nxt = ST_ITER;
        end else if (op_r == rabe_pkg::OP_DIV) begin
          acc_nxt  = '0;
          negq_nxt = rda_r[rabe_pkg::DATA_W-1] ^ rdb_r[rabe_pkg::DATA_W-1];
          opx_nxt  = rda_r[rabe_pkg::DATA_W-1] ? (~rda_r + rabe_pkg::DATA_W'(1)) : rda_r;
          opy_nxt  = rdb_r[rabe_pkg::DATA_W-1] ? (~rdb_r + rabe_pkg::DATA_W'(1)) : rdb_r;
          if (rdb_r == '0) begin
            dz_nxt    = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_ITER;
          end
        end else begin
          acc_nxt   = unit_sum[rabe_pkg::DATA_W-1:0];
          state_nxt = ST_FINISH;
        end
      end
      ST_ITER: begin
        cnt_nxt = cnt_r + rabe_pkg::CNT_W'(1);
        if (op_r == rabe_pkg::OP_DIV) begin
          acc_nxt = div_ge ? unit_sum[rabe_pkg::DATA_W-1:0]
                           : {acc_r[rabe_pkg::DATA_W-2:0], opx_r[rabe_pkg::DATA_W-1]};
          opx_nxt = {opx_r[rabe_pkg::DATA_W-2:0], div_ge};
        end else begin
          acc_nxt = unit_sum[rabe_pkg::DATA_W-1:0];
          opx_nxt = {opx_r[rabe_pkg::DATA_W-2:0], 1'b0};
          opy_nxt = {1'b0, opy_r[rabe_pkg::DATA_W-1:1]};
        end
        if (iter_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          ov_nxt     = 1'b1;
          owe_nxt    = !is_branch;
          oreg_nxt   = is_branch ? '0 : r1_r;
          oval_nxt   = is_branch ? '0 : rf_wdata;
          obub_nxt   = is_branch;
          odz_nxt    = (op_r == rabe_pkg::OP_DIV) && dz_r;
          otaken_nxt = (op_r == rabe_pkg::OP_B) ||
                       ((op_r == rabe_pkg::OP_BEQ) && (acc_r == '0)) ||
                       ((op_r == rabe_pkg::OP_BNQ) && (acc_r != '0));
          oidx_nxt   = otaken_nxt ? target_r : '0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    op_r     <= op_nxt;
    r1_r     <= r1_nxt;
    r2_r     <= r2_nxt;
    r3_r     <= r3_nxt;
    imm_r    <= imm_nxt;
    target_r <= target_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    opx_r    <= opx_nxt;
    opy_r    <= opy_nxt;
    negq_r   <= negq_nxt;
    dz_r     <= dz_nxt;
    owe_r    <= owe_nxt;
    oreg_r   <= oreg_nxt;
    oval_r   <= oval_nxt;
    otaken_r <= otaken_nxt;
    oidx_r   <= oidx_nxt;
    obub_r   <= obub_nxt;
    odz_r    <= odz_nxt;
  end

  // Initial-value registers, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < rabe_pkg::REG_COUNT; k++) begin
        init_r[k] <= '0;
      end
    end else if (cfg_write_enable) begin
      init_r[cfg_index] <= cfg_data;
    end
  end

  // Entry valid bits: an entry not yet written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
    end else if (rf_we) begin
      rf_valid_r[rf_waddr] <= 1'b1;
    end
  end

  // Register file storage with registered read data.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    rda_r <= rf_valid_r[rf_raddr_a] ? rf_mem[rf_raddr_a] : '0;
    rdb_r <= rf_valid_r[rf_raddr_b] ? rf_mem[rf_raddr_b] : '0;
  end

  // A beat taken on the input holds off the next one on the following cycle.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input accepted a second beat back to back");

  // A zero divisor always reports a register write of zero.
  a_dz_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_write_enable && (out_write_value == '0)))
    else $error("divide by zero result is not a zero write");

  // Branch results never write a register, and ALU results never branch.
  a_branch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fetch_bubbles != out_write_enable) &&
                  (!out_branch_taken || out_fetch_bubbles))
    else $error("result mixes a register write with a branch");

  // After a reload sweep every register file entry holds a written value.
  a_reload_complete: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_READ) && ($past(state_r) == ST_RELOAD)) |-> (&rf_valid_r))
    else $error("reload sweep left entries unwritten");

  // A result that is still stalled is not overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(oval_r) && $stable(oreg_r)))
    else $error("pending result overwritten while stalled");

endmodule

`default_nettype wire
